@@ hdl/indexed_shift_list_assert.svh @@
// Assertion macros shared by the indexed shift list checker.
`ifndef INDEXED_SHIFT_LIST_ASSERT_SVH
`define INDEXED_SHIFT_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ISL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ISL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/isl_pkg.sv @@
// Shared types and constants of the indexed shift list.
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned MaxDepth     = 64;
  // Width that holds any length or position up to the largest depth.
  localparam int unsigned CntW         = $clog2(MaxDepth + 1);
  localparam int unsigned DataW        = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned PosW         = 5;
  localparam int unsigned OutCntW      = 5;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND      = 3'd0,
    KIND_INSERT      = 3'd1,
    KIND_SET         = 3'd2,
    KIND_REMOVE_LAST = 3'd3,
    KIND_REMOVE_AT   = 3'd4,
    KIND_CLEAR       = 3'd5,
    KIND_DUMP        = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADIDX = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_INSERT,
    OP_SET,
    OP_REMOVE_LAST,
    OP_REMOVE_AT,
    OP_CLEAR,
    OP_ROTATE
  } cell_op_e;

  // Command broadcast to every cell; count is the length before the edit.
  typedef struct packed {
    cell_op_e            op;
    logic [CntW-1:0]     pos;
    logic [CntW-1:0]     count;
  } ctl_t;

endpackage

`default_nettype wire

@@ hdl/isl_cell.sv @@
// One storage cell of the list: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module isl_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire isl_pkg::ctl_t                      ctl_i,
  input  wire logic signed [isl_pkg::DataW-1:0]   value_i,
  input  wire logic signed [isl_pkg::DataW-1:0]   left_i,
  input  wire logic signed [isl_pkg::DataW-1:0]   right_i,
  output logic signed [isl_pkg::DataW-1:0]        entry_o
);

  localparam int unsigned CntW = isl_pkg::CntW;
  localparam logic [CntW-1:0] Idx   = CntW'(IDX);
  localparam logic [CntW-1:0] IdxP1 = CntW'(IDX + 1);

  logic signed [isl_pkg::DataW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      isl_pkg::OP_APPEND: begin
        if (Idx == ctl_i.count) entry_d = value_i;
      end
      isl_pkg::OP_INSERT: begin
        if (Idx == ctl_i.pos) begin
          entry_d = value_i;
        end else if (Idx > ctl_i.pos && Idx <= ctl_i.count) begin
          entry_d = left_i;
        end
      end
      isl_pkg::OP_SET: begin
        if (Idx == ctl_i.pos) entry_d = value_i;
      end
      isl_pkg::OP_REMOVE_LAST: begin
        if (IdxP1 == ctl_i.count) entry_d = '0;
      end
      isl_pkg::OP_REMOVE_AT: begin
        if (IdxP1 == ctl_i.count) begin
          entry_d = '0;
        end else if (Idx >= ctl_i.pos && IdxP1 < ctl_i.count) begin
          entry_d = right_i;
        end
      end
      isl_pkg::OP_CLEAR:  entry_d = '0;
      isl_pkg::OP_ROTATE: entry_d = right_i;
      default:            entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ hdl/isl_ctrl.sv @@
// Controller of the list: length, status decisions, dump sequencing, result register.
`timescale 1ns / 1ps
`default_nettype none

module isl_ctrl #(
  parameter int unsigned DEPTH = isl_pkg::DefaultDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [isl_pkg::KindW-1:0]          kind_i,
  input  wire logic [isl_pkg::PosW-1:0]           position_i,
  input  wire logic signed [isl_pkg::DataW-1:0]   head_i,
  output isl_pkg::ctl_t                           ctl_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [isl_pkg::DataW-1:0]        element_o,
  output logic                                    element_valid_o,
  output logic [isl_pkg::OutCntW-1:0]             count_o,
  output logic [1:0]                              status_o,
  output logic                                    last_o
);

  localparam int unsigned CntW = isl_pkg::CntW;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned KW   = $clog2(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [KW-1:0]   KLast  = KW'(DEPTH - 1);

  isl_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [KW-1:0]   k_q, k_d;

  logic                              out_valid_q;
  logic                              load_out;
  logic signed [isl_pkg::DataW-1:0]  elem_d, elem_q;
  logic                              evalid_d, evalid_q;
  logic [isl_pkg::OutCntW-1:0]       ocount_d, ocount_q;
  isl_pkg::status_e                  status_d, status_q;
  logic                              last_d, last_q;

  logic            accept, slot_free, emit;
  logic [CntW-1:0] pos_ext, count_ext, k_ext;

  assign pos_ext   = CntW'(position_i);
  assign count_ext = CntW'(count_q);
  assign k_ext     = CntW'(k_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == isl_pkg::ST_IDLE) && slot_free;
  assign accept    = in_valid_i && in_ready_o;
  assign emit      = k_ext < count_ext;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    ctl_o.op  = isl_pkg::OP_NONE;
    ctl_o.pos = pos_ext;
    ctl_o.count = count_ext;
    load_out  = 1'b0;
    elem_d    = '0;
    evalid_d  = 1'b0;
    status_d  = isl_pkg::STATUS_OK;
    last_d    = 1'b1;
    unique case (state_q)
      isl_pkg::ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (isl_pkg::kind_e'(kind_i))
            isl_pkg::KIND_APPEND: begin
              if (count_ext >= DepthC) begin
                status_d = isl_pkg::STATUS_FULL;
              end else begin
                ctl_o.op = isl_pkg::OP_APPEND;
                count_d  = count_q + 1'b1;
              end
            end
            isl_pkg::KIND_INSERT: begin
              if (pos_ext > count_ext) begin
                status_d = isl_pkg::STATUS_BADIDX;
              end else if (count_ext >= DepthC) begin
                status_d = isl_pkg::STATUS_FULL;
              end else begin
                ctl_o.op = isl_pkg::OP_INSERT;
                count_d  = count_q + 1'b1;
              end
            end
            isl_pkg::KIND_SET: begin
              if (pos_ext >= count_ext) begin
                status_d = isl_pkg::STATUS_BADIDX;
              end else begin
                ctl_o.op = isl_pkg::OP_SET;
              end
            end
            isl_pkg::KIND_REMOVE_LAST: begin
              if (count_q == '0) begin
                status_d = isl_pkg::STATUS_EMPTY;
              end else begin
                ctl_o.op = isl_pkg::OP_REMOVE_LAST;
                count_d  = count_q - 1'b1;
              end
            end
            isl_pkg::KIND_REMOVE_AT: begin
              if (count_q == '0) begin
                status_d = isl_pkg::STATUS_EMPTY;
              end else if (pos_ext >= count_ext) begin
                status_d = isl_pkg::STATUS_BADIDX;
              end else begin
                ctl_o.op = isl_pkg::OP_REMOVE_AT;
                count_d  = count_q - 1'b1;
              end
            end
            isl_pkg::KIND_CLEAR: begin
              if (pos_ext > DepthC) begin
                status_d = isl_pkg::STATUS_BADIDX;
              end else begin
                ctl_o.op = isl_pkg::OP_CLEAR;
                count_d  = CW'(pos_ext);
              end
            end
            isl_pkg::KIND_DUMP: begin
              if (count_q == '0) begin
                status_d = isl_pkg::STATUS_EMPTY;
              end else begin
                // Results come from the dump sequence instead.
                load_out = 1'b0;
                state_d  = isl_pkg::ST_DUMP;
                k_d      = '0;
              end
            end
            default: status_d = isl_pkg::STATUS_OK;
          endcase
        end
      end
      isl_pkg::ST_DUMP: begin
        // The ring turns once over all cells; the head is sent while it is a live entry.
        if (!emit || slot_free) begin
          ctl_o.op = isl_pkg::OP_ROTATE;
          if (emit) begin
            load_out = 1'b1;
            elem_d   = head_i;
            evalid_d = 1'b1;
            last_d   = (k_ext + 1'b1) == count_ext;
          end
          if (k_q == KLast) begin
            state_d = isl_pkg::ST_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: state_d = isl_pkg::ST_IDLE;
    endcase
    ocount_d = isl_pkg::OutCntW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isl_pkg::ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      elem_q   <= elem_d;
      evalid_q <= evalid_d;
      ocount_q <= ocount_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_o       = elem_q;
  assign element_valid_o = evalid_q;
  assign count_o         = ocount_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

@@ hdl/indexed_shift_list.sv @@
// Top level of the indexed shift list: controller plus a row of storage cells.
`timescale 1ns / 1ps
`default_nettype none

// The indexed shift list keeps up to DEPTH signed 32-bit entries in order,
// one entry in each cell of a row, plus a length. Append, insert, set, remove
// last, remove at and clear each take one transfer: the controller decides
// the status from the length and the position, and every cell works out its
// own move in the same cycle (load the value, take its left neighbor to open
// a gap, take its right neighbor to close one, or zero itself), so such items
// are taken in back-to-back cycles as long as each status result is taken in
// turn. Every one of these items returns a single result with the new length,
// the status and last set. A dump turns the row once around as a ring, one
// step per cycle unless the result side stalls, one ring step per cell after
// its own transfer, and sends the entry at the head while it is still a live
// entry; it returns one result per entry with last on the final one, and no
// new item is accepted until the ring is back in order. A dump of an empty
// list returns one empty result.
// Entries and length are zero after reset, with no clearing pass. The
// count output carries the length in five bits, so it wraps when DEPTH is
// above 31.
module indexed_shift_list #(
  parameter int unsigned DEPTH = isl_pkg::DefaultDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [isl_pkg::KindW-1:0]          kind_i,
  input  wire logic [isl_pkg::PosW-1:0]           position_i,
  input  wire logic signed [isl_pkg::DataW-1:0]   value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [isl_pkg::DataW-1:0]        element_o,
  output logic                                    element_valid_o,
  output logic [isl_pkg::OutCntW-1:0]             count_o,
  output logic [1:0]                              status_o,
  output logic                                    last_o
);

  // Command that every cell sees in the current cycle.
  isl_pkg::ctl_t ctl;

  // Entry held by each cell; cell zero is the head of the list.
  logic signed [isl_pkg::DataW-1:0] entry_w [DEPTH];

  isl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .position_i      (position_i),
    .head_i          (entry_w[0]),
    .ctl_o           (ctl),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .element_o       (element_o),
    .element_valid_o (element_valid_o),
    .count_o         (count_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // The first cell has no left neighbor, and the last cell's right neighbor
  // is the head, which closes the ring that a dump turns.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [isl_pkg::DataW-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_left
      assign left_w = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_final
      assign right_w = entry_w[0];
    end else begin : g_inner_right
      assign right_w = entry_w[i+1];
    end

    isl_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i])
    );
  end

endmodule

`default_nettype wire

@@ hdl/isl_checker.sv @@
// Port-level checker of the indexed shift list and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_shift_list_assert.svh"

module isl_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic signed [isl_pkg::DataW-1:0]   element_o,
  input wire logic                               element_valid_o,
  input wire logic [isl_pkg::OutCntW-1:0]        count_o,
  input wire logic [1:0]                         status_o,
  input wire logic                               last_o
);

  // A dumped entry always carries an ok status.
  `ISL_ASSERT_IMP(a_entry_ok, out_valid_o && element_valid_o, status_o == isl_pkg::STATUS_OK, "dumped entry with a status other than ok")

  // Status results carry a zero element and close their item.
  `ISL_ASSERT_IMP(a_status_form, out_valid_o && !element_valid_o, element_o == '0 && last_o, "status result with an element or without last")

  // No new item is taken while a dump still has entries to send.
  `ISL_ASSERT_IMP(a_dump_blocks, out_valid_o && element_valid_o && !last_o, !in_ready_o, "input accepted in the middle of a dump")

  // A stalled result holds its payload.
  `ISL_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(element_o) && $stable(count_o) && $stable(status_o) && $stable(last_o), "stalled result changed")

endmodule

bind indexed_shift_list isl_checker u_isl_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the indexed shift list: directed table, random edits and dumps.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LIST_DEPTH    = isl_pkg::DefaultDepth;
  localparam int          RANDOM_ITEMS  = 405;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          CYCLE_LIMIT   = 500000;
  // Kind 7 has no meaning in the block and must behave as a no-op.
  localparam logic [isl_pkg::KindW-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [isl_pkg::KindW-1:0]   kind;
    logic [isl_pkg::PosW-1:0]    pos;
    logic [isl_pkg::DataW-1:0]   value;
    bit                          typed;
    logic [isl_pkg::OutCntW-1:0] count;
    isl_pkg::status_e            status;
  } list_op_t;

  typedef struct packed {
    logic [isl_pkg::DataW-1:0]   element;
    logic                        element_valid;
    logic [isl_pkg::OutCntW-1:0] count;
    isl_pkg::status_e            status;
    logic                        last;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [isl_pkg::KindW-1:0] kind_i = '0;
  logic [isl_pkg::PosW-1:0] position_i = '0;
  logic signed [isl_pkg::DataW-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [isl_pkg::DataW-1:0] element_o;
  logic element_valid_o;
  logic [isl_pkg::OutCntW-1:0] count_o;
  logic [1:0] status_o;
  logic last_o;

  // Expected result of a directed row travels with the transfer it belongs to.
  bit                          row_typed = 1'b0;
  logic [isl_pkg::OutCntW-1:0] row_count = '0;
  isl_pkg::status_e            row_status = isl_pkg::STATUS_OK;

  // Model of the list contents as seen by accepted transfers.
  logic [isl_pkg::DataW-1:0] list_mem [LIST_DEPTH];
  int               list_len = 0;
  list_result_t     pending_results [$];

  // Length the stimulus generator believes the list has, used to aim positions.
  int plan_len = 0;
  bit idle_on = 1'b1;
  bit grow = 1'b1;
  bit rx_hold_req = 1'b0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  list_op_t directed_ops [25];

  indexed_shift_list #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .element_o      (element_o),
    .element_valid_o(element_valid_o),
    .count_o        (count_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      list_mem[i] = '0;
    end
  end

  function automatic void push_result(logic [isl_pkg::DataW-1:0] elem, logic ev,
                                      isl_pkg::status_e st, logic lst);
    list_result_t r;
    r.element       = elem;
    r.element_valid = ev;
    r.count         = isl_pkg::OutCntW'(list_len);
    r.status        = st;
    r.last          = lst;
    pending_results.push_back(r);
  endfunction

  // Applies one operation to the modeled list and queues the results it causes.
  function automatic void apply_list_op(logic [isl_pkg::KindW-1:0] k,
                                        logic [isl_pkg::PosW-1:0] p,
                                        logic [isl_pkg::DataW-1:0] v);
    isl_pkg::status_e st;
    int at;
    st = isl_pkg::STATUS_OK;
    at = int'(p);
    case (k)
      isl_pkg::KIND_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          st = isl_pkg::STATUS_FULL;
        end else begin
          list_mem[list_len] = v;
          list_len++;
        end
      end
      isl_pkg::KIND_INSERT: begin
        // The position is judged before fullness.
        if (at > list_len) begin
          st = isl_pkg::STATUS_BADIDX;
        end else if (list_len >= LIST_DEPTH) begin
          st = isl_pkg::STATUS_FULL;
        end else begin
          for (int i = list_len; i > at; i--) begin
            list_mem[i] = list_mem[i-1];
          end
          list_mem[at] = v;
          list_len++;
        end
      end
      isl_pkg::KIND_SET: begin
        if (at >= list_len) begin
          st = isl_pkg::STATUS_BADIDX;
        end else begin
          list_mem[at] = v;
        end
      end
      isl_pkg::KIND_REMOVE_LAST: begin
        if (list_len == 0) begin
          st = isl_pkg::STATUS_EMPTY;
        end else begin
          list_len--;
          list_mem[list_len] = '0;
        end
      end
      isl_pkg::KIND_REMOVE_AT: begin
        if (list_len == 0) begin
          st = isl_pkg::STATUS_EMPTY;
        end else if (at >= list_len) begin
          st = isl_pkg::STATUS_BADIDX;
        end else begin
          for (int i = at; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i+1];
          end
          list_len--;
          list_mem[list_len] = '0;
        end
      end
      isl_pkg::KIND_CLEAR: begin
        if (at > LIST_DEPTH) begin
          st = isl_pkg::STATUS_BADIDX;
        end else begin
          for (int i = 0; i < LIST_DEPTH; i++) begin
            list_mem[i] = '0;
          end
          list_len = at;
        end
      end
      isl_pkg::KIND_DUMP: begin
        if (list_len == 0) begin
          push_result('0, 1'b0, isl_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            push_result(list_mem[i], 1'b1, isl_pkg::STATUS_OK, i == list_len - 1);
          end
        end
        return;
      end
      default: ;
    endcase
    push_result('0, 1'b0, st, 1'b1);
  endfunction

  task automatic check_field(string what, logic [isl_pkg::DataW-1:0] exp,
                             logic [isl_pkg::DataW-1:0] got);
    if (got !== exp) begin
      fail_cnt++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp, got);
    end
  endtask

  // Input transfers update the model first, so a result leaving in the same
  // cycle still finds its expectation in place.
  always @(posedge clk_i) begin : result_monitor
    list_result_t want;
    list_result_t typed_res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_list_op(kind_i, position_i, value_i);
        if (row_typed) begin
          void'(pending_results.pop_back());
          typed_res.element       = '0;
          typed_res.element_valid = 1'b0;
          typed_res.count         = row_count;
          typed_res.status        = row_status;
          typed_res.last          = 1'b1;
          pending_results.push_back(typed_res);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          fail_cnt++;
          $display("%0t ns: result with nothing expected, element 0x%0h count %0d status %0d",
                   $time, element_o, count_o, status_o);
        end else begin
          want = pending_results.pop_front();
          check_field("element", want.element, element_o);
          check_field("element_valid", 32'(want.element_valid), 32'(element_valid_o));
          check_field("count", 32'(want.count), 32'(count_o));
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, free-running stretches, and one long hold-off
  // on request so that the block backs up and stops taking transfers.
  initial begin
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Offers one transfer and returns at the edge where it is taken.
  task automatic offer_item(logic [isl_pkg::KindW-1:0] k, logic [isl_pkg::PosW-1:0] p,
                            logic [isl_pkg::DataW-1:0] v, bit typed,
                            logic [isl_pkg::OutCntW-1:0] c, isl_pkg::status_e s);
    in_valid_i <= 1'b1;
    kind_i     <= k;
    position_i <= p;
    value_i    <= v;
    row_typed  <= typed;
    row_count  <= c;
    row_status <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pause_sender($urandom_range(1, 13));
    end
  endtask

  task automatic wait_results_drained();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [isl_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Chooses a position inside [0, span) most of the time, anywhere otherwise.
  function automatic logic [isl_pkg::PosW-1:0] pick_pos(int span);
    if (span > 0 && $urandom_range(0, 9) != 0) begin
      return isl_pkg::PosW'($urandom_range(0, span - 1));
    end
    return isl_pkg::PosW'($urandom_range(0, 31));
  endfunction

  // Draws one random operation, biased toward well-formed positions, and
  // tracks the length it should leave behind.
  task automatic draw_random_op(output logic [isl_pkg::KindW-1:0] k,
                                output logic [isl_pkg::PosW-1:0] p);
    int r;
    r = $urandom_range(0, 99);
    if (grow && r >= 68 && $urandom_range(0, 1) == 0) begin
      r = 20;
    end
    p = isl_pkg::PosW'($urandom_range(0, 31));
    if (r < 2) begin
      k = KIND_UNUSED;
    end else if (r < 5) begin
      k = isl_pkg::KIND_CLEAR;
      p = ($urandom_range(0, 4) == 0) ? isl_pkg::PosW'($urandom_range(17, 31))
                                      : isl_pkg::PosW'($urandom_range(0, LIST_DEPTH));
    end else if (r < 13) begin
      k = isl_pkg::KIND_DUMP;
    end else if (r < 33) begin
      k = isl_pkg::KIND_APPEND;
    end else if (r < 53) begin
      k = isl_pkg::KIND_INSERT;
      p = pick_pos(plan_len + 1);
    end else if (r < 68) begin
      k = isl_pkg::KIND_SET;
      p = pick_pos(plan_len);
    end else if (r < 80) begin
      k = isl_pkg::KIND_REMOVE_LAST;
    end else begin
      k = isl_pkg::KIND_REMOVE_AT;
      p = pick_pos(plan_len);
    end
    case (k)
      isl_pkg::KIND_APPEND: if (plan_len < LIST_DEPTH) plan_len++;
      isl_pkg::KIND_INSERT: if (int'(p) <= plan_len && plan_len < LIST_DEPTH) plan_len++;
      isl_pkg::KIND_REMOVE_LAST: if (plan_len > 0) plan_len--;
      isl_pkg::KIND_REMOVE_AT: if (plan_len > 0 && int'(p) < plan_len) plan_len--;
      isl_pkg::KIND_CLEAR: if (int'(p) <= LIST_DEPTH) plan_len = int'(p);
      default: ;
    endcase
  endtask

  initial begin
    logic [isl_pkg::KindW-1:0] k;
    logic [isl_pkg::PosW-1:0] p;

    // Rows whose result is obvious carry it; the two non-empty dumps rely on the model.
    directed_ops = '{
      '{isl_pkg::KIND_DUMP,        5'd0,  32'h0,         1'b1, 5'd0,  isl_pkg::STATUS_EMPTY},
      '{isl_pkg::KIND_REMOVE_LAST, 5'd0,  32'h0,         1'b1, 5'd0,  isl_pkg::STATUS_EMPTY},
      '{isl_pkg::KIND_REMOVE_AT,   5'd0,  32'h0,         1'b1, 5'd0,  isl_pkg::STATUS_EMPTY},
      '{isl_pkg::KIND_SET,         5'd0,  32'h1234_5678, 1'b1, 5'd0,  isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_INSERT,      5'd1,  32'h1,         1'b1, 5'd0,  isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_APPEND,      5'd0,  32'h7fff_ffff, 1'b1, 5'd1,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_APPEND,      5'd31, 32'h8000_0000, 1'b1, 5'd2,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_INSERT,      5'd0,  32'hffff_ffff, 1'b1, 5'd3,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_INSERT,      5'd3,  32'h0,         1'b1, 5'd4,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_SET,         5'd1,  32'h5555_5555, 1'b1, 5'd4,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_SET,         5'd4,  32'h2,         1'b1, 5'd4,  isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_REMOVE_AT,   5'd4,  32'h0,         1'b1, 5'd4,  isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_REMOVE_AT,   5'd1,  32'h0,         1'b1, 5'd3,  isl_pkg::STATUS_OK},
      '{KIND_UNUSED,               5'd31, 32'hffff_ffff, 1'b1, 5'd3,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_DUMP,        5'd0,  32'h0,         1'b0, 5'd0,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_CLEAR,       5'd17, 32'h0,         1'b1, 5'd3,  isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_CLEAR,       5'd31, 32'h0,         1'b1, 5'd3,  isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_CLEAR,       5'd16, 32'h0,         1'b1, 5'd16, isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_APPEND,      5'd0,  32'h3,         1'b1, 5'd16, isl_pkg::STATUS_FULL},
      '{isl_pkg::KIND_INSERT,      5'd16, 32'h4,         1'b1, 5'd16, isl_pkg::STATUS_FULL},
      '{isl_pkg::KIND_INSERT,      5'd17, 32'h5,         1'b1, 5'd16, isl_pkg::STATUS_BADIDX},
      '{isl_pkg::KIND_SET,         5'd15, 32'haaaa_aaaa, 1'b1, 5'd16, isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_DUMP,        5'd0,  32'h0,         1'b0, 5'd0,  isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_REMOVE_LAST, 5'd0,  32'h0,         1'b1, 5'd15, isl_pkg::STATUS_OK},
      '{isl_pkg::KIND_CLEAR,       5'd0,  32'h0,         1'b1, 5'd0,  isl_pkg::STATUS_OK}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i]) begin
      offer_item(directed_ops[i].kind, directed_ops[i].pos, directed_ops[i].value,
                 directed_ops[i].typed, directed_ops[i].count, directed_ops[i].status);
      maybe_idle();
    end
    plan_len = 0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Phases: idling, a calm stretch, a long result hold-off with the sender
      // pushing, a full drain, idling again, and a calm finish.
      if (n == 120) idle_on = 1'b0;
      if (n == 160) rx_hold_req = 1'b1;
      if (n == 200) begin
        wait_results_drained();
        idle_on = 1'b1;
      end
      if (n == 340) idle_on = 1'b0;
      if (n % 32 == 0) grow = ~grow;
      draw_random_op(k, p);
      offer_item(k, p, pick_value(), 1'b0, '0, isl_pkg::STATUS_OK);
      maybe_idle();
    end

    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * LIST_DEPTH) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
